/* src/midi_track_event_parser_core_assert.svh */
// assertion macros shared by the parser core
`ifndef MIDI_TRACK_EVENT_PARSER_CORE_ASSERT_SVH
`define MIDI_TRACK_EVENT_PARSER_CORE_ASSERT_SVH
`ifndef NO_ASSERTIONS
// condition must hold at every clock edge outside reset
`define MTEP_ASSERT_ALWAYS(label, clk, rst, cond) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) \
      else $error("parser check failed");
// antecedent implies consequent at the next clock
`define MTEP_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("parser check failed");
`else
`define MTEP_ASSERT_ALWAYS(label, clk, rst, cond)
`define MTEP_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

/* src/mtep_pkg.sv */
// types, codes and helpers of the midi track event parser
package mtep_pkg;

   // parse phases
   typedef enum logic [2:0] {
      PH_DELTA   = 3'd0,
      PH_STATUS  = 3'd1,
      PH_DATA1   = 3'd2,
      PH_DATA2   = 3'd3,
      PH_MTYPE   = 3'd4,
      PH_LENGTH  = 3'd5,
      PH_PAYLOAD = 3'd6
   } phase_type;

   // result kinds
   typedef enum logic [2:0] {
      KIND_SHORT   = 3'd0,
      KIND_SYSEX   = 3'd1,
      KIND_META    = 3'd2,
      KIND_PAYLOAD = 3'd3,
      KIND_TRUNC   = 3'd4
   } kind_type;

   // data size class of a status byte
   typedef enum logic [2:0] {
      SZ_NONE,
      SZ_ONE,
      SZ_TWO,
      SZ_SYSEX,
      SZ_META
   } size_type;

   localparam logic [7:0] DATA_MASK   = 8'h7F;
   localparam logic [7:0] STATUS_FLAG = 8'h80;
   localparam logic [7:0] SYSTEM_BASE = 8'hF0;
   localparam logic [7:0] META_STATUS = 8'hFF;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       track_last;
   } item_type;

   typedef struct packed {
      logic [2:0]  event_kind;
      logic [31:0] event_time;
      logic [7:0]  status_byte;
      logic [7:0]  first_data;
      logic [7:0]  second_data;
      logic [7:0]  meta_kind;
      logic [27:0] payload_length;
      logic [7:0]  payload_value;
      logic        event_done;
   } result_type;

   typedef struct packed {
      phase_type   phase;
      logic [7:0]  running_status;
      logic [31:0] time_total;
      logic [27:0] quantity_accum;
      logic [1:0]  quantity_bytes;
      logic [7:0]  held_data;
      logic [7:0]  held_meta_kind;
      logic [27:0] bytes_remaining;
   } state_type;

   localparam state_type STATE_RESET = '{
      phase:           PH_DELTA,
      running_status:  8'h00,
      time_total:      32'd0,
      quantity_accum:  28'd0,
      quantity_bytes:  2'd0,
      held_data:       8'h00,
      held_meta_kind:  8'h00,
      bytes_remaining: 28'd0
   };

   // how many data bytes follow a status
   function automatic size_type size_of(input logic [7:0] st);
      size_type sz;
      case (st) inside
         [8'h00:8'hBF]:  sz = SZ_TWO;
         [8'hC0:8'hDF]:  sz = SZ_ONE;
         [8'hE0:8'hEF]:  sz = SZ_TWO;
         8'hF1, 8'hF3:   sz = SZ_ONE;
         8'hF2:          sz = SZ_TWO;
         8'hF0, 8'hF7:   sz = SZ_SYSEX;
         8'hFF:          sz = SZ_META;
         default:        sz = SZ_NONE;
      endcase
      return sz;
   endfunction

endpackage

/* src/mtep_req_if.sv */
// byte channel into the parser
interface mtep_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       track_last;

   modport source (output valid, output data_byte, output track_last, input ready);
   modport sink (input valid, input data_byte, input track_last, output ready);
endinterface

/* src/mtep_rsp_if.sv */
// event result channel out of the parser
interface mtep_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  event_kind;
   logic [31:0] event_time;
   logic [7:0]  status_byte;
   logic [7:0]  first_data;
   logic [7:0]  second_data;
   logic [7:0]  meta_kind;
   logic [27:0] payload_length;
   logic [7:0]  payload_value;
   logic        event_done;

   modport source (
      output valid, output event_kind, output event_time, output status_byte,
      output first_data, output second_data, output meta_kind,
      output payload_length, output payload_value, output event_done,
      input ready
   );
   modport sink (
      input valid, input event_kind, input event_time, input status_byte,
      input first_data, input second_data, input meta_kind,
      input payload_length, input payload_value, input event_done,
      output ready
   );
endinterface

/* src/midi_track_event_parser_core.sv */
// Standard MIDI file track body parser. Takes one track byte per item and
// returns at most one event result per byte: short channel or system events,
// sysex and meta headers, one result per sysex or meta payload byte, and a
// truncated result when the track ends inside an event. Delta times are summed
// into a wrapping 32-bit tick count, and running status is honored. A byte is
// accepted every clock cycle while results drain; its result passes from the
// input register through the single combinational parse step into the result
// register, where it is offered. A stalled result holds the byte in the input
// register and blocks further input. The byte flagged as last in the track
// resets all parser state, including the tick count.
module midi_track_event_parser_core
   import mtep_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   mtep_req_if.sink   req_chan,
   mtep_rsp_if.source rsp_chan
);

`include "midi_track_event_parser_core_assert.svh"

   item_type   in_ff, in_in;
   logic       in_valid_ff, in_valid_in;
   state_type  state_ff, state_in;
   result_type out_ff, out_in;
   logic       out_valid_ff, out_valid_in;

   logic       advance;
   state_type  step_state;
   logic       step_has;
   result_type step_res;

   // the held byte moves on when the result register is free or drains
   assign advance = in_valid_ff && (!out_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !in_valid_ff || advance;

   mtep_step u_step (
      .cur_state  (state_ff),
      .item       (in_ff),
      .next_state (step_state),
      .has_result (step_has),
      .result     (step_res)
   );

   // input register
   always_comb begin
      in_in = in_ff;
      in_valid_in = in_valid_ff;
      if (req_chan.valid && req_chan.ready) begin
         in_in.data_byte = req_chan.data_byte;
         in_in.track_last = req_chan.track_last;
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
   end

   // parser state and result register
   always_comb begin
      state_in = state_ff;
      out_in = out_ff;
      out_valid_in = out_valid_ff;
      if (advance) begin
         state_in = step_state;
         out_valid_in = step_has;
         if (step_has) begin
            out_in = step_res;
         end
      end else if (rsp_chan.ready) begin
         out_valid_in = 1'b0;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         out_valid_ff <= 1'b0;
         state_ff <= STATE_RESET;
      end else begin
         in_valid_ff <= in_valid_in;
         out_valid_ff <= out_valid_in;
         state_ff <= state_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      in_ff <= in_in;
      out_ff <= out_in;
   end

   assign rsp_chan.valid = out_valid_ff;
   assign rsp_chan.event_kind = out_ff.event_kind;
   assign rsp_chan.event_time = out_ff.event_time;
   assign rsp_chan.status_byte = out_ff.status_byte;
   assign rsp_chan.first_data = out_ff.first_data;
   assign rsp_chan.second_data = out_ff.second_data;
   assign rsp_chan.meta_kind = out_ff.meta_kind;
   assign rsp_chan.payload_length = out_ff.payload_length;
   assign rsp_chan.payload_value = out_ff.payload_value;
   assign rsp_chan.event_done = out_ff.event_done;

   // a full pipe with a stalled result must not take a byte
   `MTEP_ASSERT_ALWAYS(a_stall_blocks_input, clock, reset,
      !(in_valid_ff && out_valid_ff && !rsp_chan.ready) || !req_chan.ready)

   // last byte of a track leaves the parser at the delta phase with time zero
   `MTEP_ASSERT_NEXT(a_track_end_clears, clock, reset, advance && in_ff.track_last,
      state_ff.phase == PH_DELTA && state_ff.time_total == 32'd0
      && state_ff.running_status == 8'h00)

   // short events never carry sysex or meta fields
   `MTEP_ASSERT_ALWAYS(a_short_clean, clock, reset,
      !(out_valid_ff && out_ff.event_kind == KIND_SHORT)
      || (out_ff.meta_kind == 8'h00 && out_ff.payload_length == 28'd0 && out_ff.event_done))

endmodule

/* src/mtep_step.sv */
// one-byte parse step: next state and optional result
module mtep_step
   import mtep_pkg::*;
(
   input  state_type  cur_state,
   input  item_type   item,
   output state_type  next_state,
   output logic       has_result,
   output result_type result
);

   logic [7:0]  b;
   logic [27:0] vlq_acc;
   logic        vlq_done;
   logic [1:0]  vlq_bytes;
   logic [27:0] remain;
   logic        was_payload;
   state_type   nxt;

   // close an event: system status drops running status
   function automatic state_type end_event(input state_type s);
      state_type r;
      r = s;
      if (s.running_status >= SYSTEM_BASE) begin
         r.running_status = 8'h00;
      end
      r.held_data = 8'h00;
      r.held_meta_kind = 8'h00;
      r.quantity_accum = 28'd0;
      r.quantity_bytes = 2'd0;
      r.bytes_remaining = 28'd0;
      r.phase = PH_DELTA;
      return r;
   endfunction

   assign b = item.data_byte;

   // variable-length quantity, ends at four bytes
   assign vlq_acc = {cur_state.quantity_accum[20:0], 7'(b & DATA_MASK)};
   assign vlq_done = ((b & STATUS_FLAG) == 8'h00) || (cur_state.quantity_bytes == 2'd3);
   assign vlq_bytes = vlq_done ? 2'd0 : cur_state.quantity_bytes + 2'd1;
   assign remain = (cur_state.bytes_remaining != 28'd0) ?
                   cur_state.bytes_remaining - 28'd1 : 28'd0;

   // phase decode
   always_comb begin
      nxt = cur_state;
      has_result = 1'b0;
      result = '0;
      result.event_time = cur_state.time_total;
      was_payload = 1'b0;
      case (cur_state.phase)
         PH_STATUS: begin
            if ((b & STATUS_FLAG) != 8'h00) begin
               nxt.running_status = b;
               case (size_of(b))
                  SZ_NONE: begin
                     has_result = 1'b1;
                     result.event_kind = KIND_SHORT;
                     result.status_byte = b;
                     result.event_done = 1'b1;
                     nxt = end_event(nxt);
                  end
                  SZ_ONE, SZ_TWO: begin
                     nxt.phase = PH_DATA1;
                  end
                  SZ_SYSEX: begin
                     nxt.held_meta_kind = 8'h00;
                     nxt.quantity_accum = 28'd0;
                     nxt.quantity_bytes = 2'd0;
                     nxt.phase = PH_LENGTH;
                  end
                  default: begin
                     nxt.phase = PH_MTYPE;
                  end
               endcase
            end else if (cur_state.running_status == 8'h00) begin
               // orphan data byte taken as a one-byte delta
               nxt.time_total = cur_state.time_total + 32'(b & DATA_MASK);
               nxt.quantity_accum = 28'd0;
               nxt.quantity_bytes = 2'd0;
            end else if (size_of(cur_state.running_status) == SZ_ONE) begin
               has_result = 1'b1;
               result.event_kind = KIND_SHORT;
               result.status_byte = cur_state.running_status;
               result.first_data = b;
               result.event_done = 1'b1;
               nxt = end_event(nxt);
            end else begin
               nxt.held_data = b;
               nxt.phase = PH_DATA2;
            end
         end
         PH_DATA1: begin
            if (size_of(cur_state.running_status) == SZ_ONE) begin
               has_result = 1'b1;
               result.event_kind = KIND_SHORT;
               result.status_byte = cur_state.running_status;
               result.first_data = b;
               result.event_done = 1'b1;
               nxt = end_event(nxt);
            end else begin
               nxt.held_data = b;
               nxt.phase = PH_DATA2;
            end
         end
         PH_DATA2: begin
            has_result = 1'b1;
            result.event_kind = KIND_SHORT;
            result.status_byte = cur_state.running_status;
            result.first_data = cur_state.held_data;
            result.second_data = b;
            result.event_done = 1'b1;
            nxt = end_event(nxt);
         end
         PH_MTYPE: begin
            nxt.held_meta_kind = b;
            nxt.quantity_accum = 28'd0;
            nxt.quantity_bytes = 2'd0;
            nxt.phase = PH_LENGTH;
         end
         PH_LENGTH: begin
            nxt.quantity_accum = vlq_acc;
            nxt.quantity_bytes = vlq_bytes;
            if (vlq_done) begin
               nxt.bytes_remaining = vlq_acc;
               has_result = 1'b1;
               result.event_kind = (cur_state.running_status == META_STATUS) ?
                                   KIND_META : KIND_SYSEX;
               result.status_byte = cur_state.running_status;
               result.meta_kind = cur_state.held_meta_kind;
               result.payload_length = vlq_acc;
               result.event_done = (vlq_acc == 28'd0);
               if (vlq_acc == 28'd0) begin
                  nxt = end_event(nxt);
               end else begin
                  nxt.phase = PH_PAYLOAD;
               end
            end
         end
         PH_PAYLOAD: begin
            was_payload = 1'b1;
            nxt.bytes_remaining = remain;
            has_result = 1'b1;
            result.event_kind = KIND_PAYLOAD;
            result.status_byte = cur_state.running_status;
            result.meta_kind = cur_state.held_meta_kind;
            result.payload_length = cur_state.quantity_accum;
            result.payload_value = b;
            result.event_done = (remain == 28'd0);
            if (remain == 28'd0) begin
               nxt = end_event(nxt);
            end
         end
         default: begin
            // delta time
            nxt.phase = PH_DELTA;
            nxt.quantity_accum = vlq_acc;
            nxt.quantity_bytes = vlq_bytes;
            if (vlq_done) begin
               nxt.time_total = cur_state.time_total + 32'(vlq_acc);
               nxt.quantity_accum = 28'd0;
               nxt.phase = PH_STATUS;
            end
         end
      endcase

      // end of track: report a cut-short event unless at an event boundary, then clear everything
      if (item.track_last) begin
         if (!(nxt.phase == PH_DELTA && nxt.quantity_bytes == 2'd0)) begin
            has_result = 1'b1;
            result = '0;
            result.event_kind = KIND_TRUNC;
            result.event_time = nxt.time_total;
            if (nxt.phase >= PH_DATA1 && nxt.phase <= PH_PAYLOAD) begin
               result.status_byte = nxt.running_status;
               result.meta_kind = nxt.held_meta_kind;
            end
            if (nxt.phase == PH_DATA2) begin
               result.first_data = nxt.held_data;
            end
            if (nxt.phase == PH_PAYLOAD) begin
               result.payload_length = nxt.quantity_accum;
            end
            if (was_payload) begin
               result.payload_value = b;
            end
            result.event_done = 1'b1;
         end
         nxt = STATE_RESET;
      end
   end

   assign next_state = nxt;

endmodule

/* dv/tb_midi_track_event_parser_core.sv */
// self-checking testbench for the midi track event parser core
module tb_midi_track_event_parser_core;
   import mtep_pkg::*;

   localparam int unsigned RANDOM_ITEMS = 700;
   localparam int unsigned QUIET_LIMIT  = 2000;
   localparam int unsigned DRAIN_CYCLES = 8;
   localparam int unsigned PRINT_LIMIT  = 40;

   // status bytes and class boundaries
   localparam logic [7:0] CHAN_FIRST     = 8'h80;
   localparam logic [7:0] CHAN_LAST      = 8'hEF;
   localparam logic [7:0] ONE_DATA_FIRST = 8'hC0;
   localparam logic [7:0] TWO_DATA_FIRST = 8'hE0;
   localparam logic [7:0] ST_SYSEX       = 8'hF0;
   localparam logic [7:0] ST_TIME_CODE   = 8'hF1;
   localparam logic [7:0] ST_SONG_POS    = 8'hF2;
   localparam logic [7:0] ST_SONG_SEL    = 8'hF3;
   localparam logic [7:0] ST_TUNE_REQ    = 8'hF6;
   localparam logic [7:0] ST_ESCAPE      = 8'hF7;
   localparam logic [7:0] ST_LAST_SYSTEM = 8'hFE;
   localparam logic [7:0] META_END_TRACK = 8'h2F;

   logic clock = 1'b0;
   logic reset;

   mtep_req_if req_bus ();
   mtep_rsp_if rsp_bus ();

   midi_track_event_parser_core dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus.sink),
      .rsp_chan (rsp_bus.source)
   );

   // clock with period 2
   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // stimulus and scoreboard storage
   item_type    pending_bytes[$];
   logic [7:0]  track_buf[$];
   result_type  expected_events[$];
   item_type    drive_item;
   item_type    taken_item;
   result_type  seen_event;
   logic [7:0]  gen_running;

   // mirror of the parser state
   state_type   pr;

   int unsigned total_items;
   int unsigned sent_count;
   int unsigned acc_count;
   int unsigned event_count;
   int unsigned trunc_count;
   int unsigned payload_count;
   int unsigned track_count;
   int unsigned mismatch_count;
   int unsigned quiet_cycles;

   // data size class of a status byte
   function automatic size_type status_class(input logic [7:0] st);
      if (st < ONE_DATA_FIRST) return SZ_TWO;
      if (st < TWO_DATA_FIRST) return SZ_ONE;
      if (st < ST_SYSEX) return SZ_TWO;
      case (st)
         ST_TIME_CODE, ST_SONG_SEL: return SZ_ONE;
         ST_SONG_POS:               return SZ_TWO;
         ST_SYSEX, ST_ESCAPE:       return SZ_SYSEX;
         META_STATUS:               return SZ_META;
         default:                   return SZ_NONE;
      endcase
   endfunction

   function automatic int unsigned data_count(input logic [7:0] st);
      case (status_class(st))
         SZ_ONE:  return 1;
         SZ_TWO:  return 2;
         default: return 0;
      endcase
   endfunction

   // one byte of a variable-length quantity, complete after a clear top bit or four bytes
   task automatic take_quantity(input logic [7:0] b, output logic complete);
      pr.quantity_accum = {pr.quantity_accum[20:0], b[6:0]};
      if (b[7] && pr.quantity_bytes < 2'd3) begin
         pr.quantity_bytes = pr.quantity_bytes + 2'd1;
         complete = 1'b0;
      end else begin
         pr.quantity_bytes = 2'd0;
         complete = 1'b1;
      end
   endtask

   // back to the delta phase, system statuses drop running status
   task automatic close_event();
      if (pr.running_status >= SYSTEM_BASE) pr.running_status = 8'h00;
      pr.held_data       = 8'h00;
      pr.held_meta_kind  = 8'h00;
      pr.quantity_accum  = 28'd0;
      pr.quantity_bytes  = 2'd0;
      pr.bytes_remaining = 28'd0;
      pr.phase           = PH_DELTA;
   endtask

   function automatic result_type make_result(input logic [2:0] kind, input logic [7:0] st,
                                              input logic [7:0] d1, input logic [7:0] d2,
                                              input logic [7:0] mk, input logic [27:0] len,
                                              input logic [7:0] pv, input logic done);
      result_type r;
      r.event_kind     = kind;
      r.event_time     = pr.time_total;
      r.status_byte    = st;
      r.first_data     = d1;
      r.second_data    = d2;
      r.meta_kind      = mk;
      r.payload_length = len;
      r.payload_value  = pv;
      r.event_done     = done;
      return r;
   endfunction

   // advance the mirror by one track byte and queue the event it gives
   task automatic predict_byte(input item_type it);
      logic [7:0] b;
      logic       was_payload;
      logic       produced;
      logic       complete;
      logic       in_event;
      size_type   sz;
      result_type ev;
      b = it.data_byte;
      was_payload = 1'b0;
      produced = 1'b0;
      case (pr.phase)
         PH_STATUS: begin
            if ((b & STATUS_FLAG) != 8'h00) begin
               pr.running_status = b;
               sz = status_class(b);
               if (sz == SZ_NONE) begin
                  ev = make_result(KIND_SHORT, b, 8'h00, 8'h00, 8'h00, 28'd0, 8'h00, 1'b1);
                  produced = 1'b1;
                  close_event();
               end else if (sz == SZ_ONE || sz == SZ_TWO) begin
                  pr.phase = PH_DATA1;
               end else if (sz == SZ_SYSEX) begin
                  pr.held_meta_kind = 8'h00;
                  pr.quantity_accum = 28'd0;
                  pr.quantity_bytes = 2'd0;
                  pr.phase = PH_LENGTH;
               end else begin
                  pr.phase = PH_MTYPE;
               end
            end else if (pr.running_status == 8'h00) begin
               // orphan data byte counts as a one-byte delta
               pr.quantity_accum = 28'd0;
               pr.quantity_bytes = 2'd0;
               take_quantity(b, complete);
               pr.time_total = pr.time_total + {4'd0, pr.quantity_accum};
               pr.quantity_accum = 28'd0;
            end else if (status_class(pr.running_status) == SZ_ONE) begin
               ev = make_result(KIND_SHORT, pr.running_status, b, 8'h00, 8'h00, 28'd0,
                                8'h00, 1'b1);
               produced = 1'b1;
               close_event();
            end else begin
               pr.held_data = b;
               pr.phase = PH_DATA2;
            end
         end
         PH_DATA1: begin
            if (status_class(pr.running_status) == SZ_ONE) begin
               ev = make_result(KIND_SHORT, pr.running_status, b, 8'h00, 8'h00, 28'd0,
                                8'h00, 1'b1);
               produced = 1'b1;
               close_event();
            end else begin
               pr.held_data = b;
               pr.phase = PH_DATA2;
            end
         end
         PH_DATA2: begin
            ev = make_result(KIND_SHORT, pr.running_status, pr.held_data, b, 8'h00, 28'd0,
                             8'h00, 1'b1);
            produced = 1'b1;
            close_event();
         end
         PH_MTYPE: begin
            pr.held_meta_kind = b;
            pr.quantity_accum = 28'd0;
            pr.quantity_bytes = 2'd0;
            pr.phase = PH_LENGTH;
         end
         PH_LENGTH: begin
            take_quantity(b, complete);
            if (complete) begin
               pr.bytes_remaining = pr.quantity_accum;
               ev = make_result(pr.running_status == META_STATUS ? KIND_META : KIND_SYSEX,
                                pr.running_status, 8'h00, 8'h00, pr.held_meta_kind,
                                pr.quantity_accum, 8'h00, pr.quantity_accum == 28'd0);
               produced = 1'b1;
               if (pr.quantity_accum == 28'd0) close_event();
               else pr.phase = PH_PAYLOAD;
            end
         end
         PH_PAYLOAD: begin
            was_payload = 1'b1;
            if (pr.bytes_remaining != 28'd0) pr.bytes_remaining = pr.bytes_remaining - 28'd1;
            ev = make_result(KIND_PAYLOAD, pr.running_status, 8'h00, 8'h00, pr.held_meta_kind,
                             pr.quantity_accum, b, pr.bytes_remaining == 28'd0);
            produced = 1'b1;
            if (pr.bytes_remaining == 28'd0) close_event();
         end
         default: begin
            pr.phase = PH_DELTA;
            take_quantity(b, complete);
            if (complete) begin
               pr.time_total = pr.time_total + {4'd0, pr.quantity_accum};
               pr.quantity_accum = 28'd0;
               pr.phase = PH_STATUS;
            end
         end
      endcase
      // end of track: inside an event, a cut-short event replaces the normal result
      if (it.track_last) begin
         if (!(pr.phase == PH_DELTA && pr.quantity_bytes == 2'd0)) begin
            in_event = (pr.phase >= PH_DATA1 && pr.phase <= PH_PAYLOAD);
            ev = make_result(KIND_TRUNC,
                             in_event ? pr.running_status : 8'h00,
                             pr.phase == PH_DATA2 ? pr.held_data : 8'h00,
                             8'h00,
                             in_event ? pr.held_meta_kind : 8'h00,
                             pr.phase == PH_PAYLOAD ? pr.quantity_accum : 28'd0,
                             was_payload ? b : 8'h00,
                             1'b1);
            produced = 1'b1;
         end
         pr = STATE_RESET;
      end
      if (produced) expected_events = {expected_events, ev};
   endtask

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      mismatch_count++;
      if (mismatch_count <= PRINT_LIMIT)
         $display("mismatch at result %0d: %s got %0h want %0h", event_count, what, got, want);
   endtask

   task automatic check_event(input result_type got, input result_type want);
      if (got.event_kind !== want.event_kind)
         report_mismatch("event_kind", 32'(got.event_kind), 32'(want.event_kind));
      if (got.event_time !== want.event_time)
         report_mismatch("event_time", got.event_time, want.event_time);
      if (got.status_byte !== want.status_byte)
         report_mismatch("status_byte", 32'(got.status_byte), 32'(want.status_byte));
      if (got.first_data !== want.first_data)
         report_mismatch("first_data", 32'(got.first_data), 32'(want.first_data));
      if (got.second_data !== want.second_data)
         report_mismatch("second_data", 32'(got.second_data), 32'(want.second_data));
      if (got.meta_kind !== want.meta_kind)
         report_mismatch("meta_kind", 32'(got.meta_kind), 32'(want.meta_kind));
      if (got.payload_length !== want.payload_length)
         report_mismatch("payload_length", 32'(got.payload_length),
                         32'(want.payload_length));
      if (got.payload_value !== want.payload_value)
         report_mismatch("payload_value", 32'(got.payload_value), 32'(want.payload_value));
      if (got.event_done !== want.event_done)
         report_mismatch("event_done", 32'(got.event_done), 32'(want.event_done));
   endtask

   // stimulus building
   task automatic push_item(input logic [7:0] b, input logic last);
      item_type it;
      it.data_byte = b;
      it.track_last = last;
      pending_bytes = {pending_bytes, it};
   endtask

   // append one byte to the track under construction
   task automatic add_byte(input logic [7:0] b);
      track_buf = {track_buf, b};
   endtask

   task automatic put_quantity(input logic [27:0] value, input int nbytes, input logic spill);
      int k;
      logic [6:0] group;
      for (k = nbytes - 1; k >= 0; k--) begin
         group = 7'(value >> (7 * k));
         add_byte({(k != 0) || spill, group});
      end
   endtask

   task automatic put_delta();
      int unsigned pick;
      int nbytes;
      pick = $urandom_range(99);
      nbytes = pick < 55 ? 1 : pick < 80 ? 2 : pick < 92 ? 3 : 4;
      if ($urandom_range(99) < 15) put_quantity(28'd0, nbytes, 1'b0);
      else put_quantity(28'($urandom), nbytes, nbytes == 4 && $urandom_range(3) == 0);
   endtask

   // data bytes, a few with the top bit set
   task automatic put_data(input int unsigned count);
      repeat (count) begin
         if ($urandom_range(99) < 8) add_byte(8'($urandom_range(255)));
         else add_byte(8'($urandom_range(127)));
      end
   endtask

   task automatic gen_event(input logic wide);
      int unsigned pick;
      int unsigned len;
      logic [7:0] st;
      pick = $urandom_range(99);
      if (pick < 6) begin
         add_byte(8'($urandom_range(255)));
         return;
      end
      if (wide) put_quantity(28'h0FFF_FFFF - 28'($urandom_range(4095)), 4,
                             1'($urandom_range(1)));
      else put_delta();
      pick = $urandom_range(99);
      if (pick < 30) begin
         // running status, or an orphan data byte when none is in force
         if (gen_running == 8'h00) put_data(1);
         else put_data(data_count(gen_running));
      end else if (pick < 62) begin
         st = 8'($urandom_range(CHAN_FIRST, CHAN_LAST));
         gen_running = st;
         add_byte(st);
         put_data(data_count(st));
      end else if (pick < 74) begin
         st = 8'($urandom_range(ST_TIME_CODE, ST_LAST_SYSTEM));
         while (st == ST_ESCAPE) st = 8'($urandom_range(ST_TIME_CODE, ST_LAST_SYSTEM));
         gen_running = 8'h00;
         add_byte(st);
         put_data(data_count(st));
      end else begin
         gen_running = 8'h00;
         if (pick < 86) st = $urandom_range(1) ? ST_SYSEX : ST_ESCAPE;
         else st = META_STATUS;
         add_byte(st);
         if (st == META_STATUS) add_byte(8'($urandom_range(255)));
         len = $urandom_range(5);
         put_quantity(28'(len), $urandom_range(99) < 20 ? 2 : 1, 1'b0);
         repeat (len) add_byte(8'($urandom_range(255)));
      end
   endtask

   // one track: random events, then a clean end, a cut, or a huge event cut short
   task automatic gen_track();
      int unsigned n_events;
      int unsigned ending;
      int unsigned cut;
      int unsigned i;
      logic wide;
      logic [7:0] st;
      track_buf.delete();
      gen_running = 8'h00;
      wide = ($urandom_range(99) < 20);
      n_events = wide ? $urandom_range(24, 17) : $urandom_range(16, 4);
      repeat (n_events) gen_event(wide);
      ending = $urandom_range(99);
      if (ending < 55) begin
         put_delta();
         add_byte(META_STATUS);
         add_byte(META_END_TRACK);
         add_byte(8'h00);
      end else if (ending < 80) begin
         cut = $urandom_range(track_buf.size() - 1);
         while (track_buf.size() > cut + 1) void'(track_buf.pop_back());
      end else begin
         put_delta();
         case ($urandom_range(2))
            0:       st = ST_SYSEX;
            1:       st = ST_ESCAPE;
            default: st = META_STATUS;
         endcase
         add_byte(st);
         if (st == META_STATUS) add_byte(8'($urandom_range(255)));
         put_quantity(28'($urandom), 4, 1'b0);
         repeat ($urandom_range(3)) add_byte(8'($urandom_range(255)));
      end
      for (i = 0; i < track_buf.size(); i++) push_item(track_buf[i], i == track_buf.size() - 1);
      track_count++;
   endtask

   // idle rates per third of the run
   function automatic int unsigned sender_idle_pct();
      if (sent_count < total_items / 3) return 21;
      if (sent_count < 2 * total_items / 3) return 54;
      return 0;
   endfunction

   function automatic int unsigned receiver_idle_pct();
      if (acc_count < total_items / 3) return 54;
      if (acc_count < 2 * total_items / 3) return 21;
      return 0;
   endfunction

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_bus.valid <= 1'b0;
         req_bus.data_byte <= 8'h00;
         req_bus.track_last <= 1'b0;
      end else if (!req_bus.valid || req_bus.ready) begin
         if (pending_bytes.size() != 0 && $urandom_range(99) >= sender_idle_pct()) begin
            drive_item = pending_bytes.pop_front();
            req_bus.valid <= 1'b1;
            req_bus.data_byte <= drive_item.data_byte;
            req_bus.track_last <= drive_item.track_last;
            sent_count <= sent_count + 1;
         end else begin
            req_bus.valid <= 1'b0;
         end
      end
   end

   // monitor: predict on accepted bytes, check accepted results, watchdog
   always @(posedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
         quiet_cycles <= 0;
      end else begin
         if (req_bus.valid && req_bus.ready) begin
            taken_item.data_byte = req_bus.data_byte;
            taken_item.track_last = req_bus.track_last;
            predict_byte(taken_item);
            acc_count = acc_count + 1;
         end
         if (rsp_bus.valid && rsp_bus.ready) begin
            seen_event.event_kind     = rsp_bus.event_kind;
            seen_event.event_time     = rsp_bus.event_time;
            seen_event.status_byte    = rsp_bus.status_byte;
            seen_event.first_data     = rsp_bus.first_data;
            seen_event.second_data    = rsp_bus.second_data;
            seen_event.meta_kind      = rsp_bus.meta_kind;
            seen_event.payload_length = rsp_bus.payload_length;
            seen_event.payload_value  = rsp_bus.payload_value;
            seen_event.event_done     = rsp_bus.event_done;
            if (expected_events.size() == 0)
               report_mismatch("unexpected result, kind", 32'(seen_event.event_kind), 32'd0);
            else
               check_event(seen_event, expected_events.pop_front());
            if (seen_event.event_kind == KIND_TRUNC) trunc_count++;
            if (seen_event.event_kind == KIND_PAYLOAD) payload_count++;
            event_count++;
         end
         if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
            quiet_cycles <= 0;
         end else if (quiet_cycles + 1 >= QUIET_LIMIT) begin
            $display("timeout: no item accepted for %0d cycles", QUIET_LIMIT);
            $display("Some tests failed");
            $finish;
         end else begin
            quiet_cycles <= quiet_cycles + 1;
         end
         rsp_bus.ready <= ($urandom_range(99) >= receiver_idle_pct());
      end
   end

   // stimulus, end of run
   initial begin
      int unsigned directed_count;
      reset = 1'b1;
      req_bus.valid = 1'b0;
      req_bus.data_byte = 8'h00;
      req_bus.track_last = 1'b0;
      rsp_bus.ready = 1'b0;
      pr = STATE_RESET;
      total_items = 0;
      sent_count = 0;
      acc_count = 0;
      event_count = 0;
      trunc_count = 0;
      payload_count = 0;
      track_count = 0;
      mismatch_count = 0;

      // note on with smallest and largest data values
      push_item(8'h00, 1'b0);
      push_item(8'h90, 1'b0);
      push_item(8'h00, 1'b0);
      push_item(8'h7F, 1'b0);
      // longest delta, top bit still set on the fourth byte
      push_item(8'hFF, 1'b0);
      push_item(8'hFF, 1'b0);
      push_item(8'hFF, 1'b0);
      push_item(8'hFF, 1'b0);
      // running status with a status byte taken as data
      push_item(8'h45, 1'b0);
      push_item(8'h80, 1'b0);
      // program change with a high data byte
      push_item(8'h00, 1'b0);
      push_item(8'hC5, 1'b0);
      push_item(8'h81, 1'b0);
      // no-data system status drops running status
      push_item(8'h00, 1'b0);
      push_item(ST_TUNE_REQ, 1'b0);
      // orphan data byte after a delta, then a sysex escape
      push_item(8'h00, 1'b0);
      push_item(8'h12, 1'b0);
      push_item(ST_ESCAPE, 1'b0);
      push_item(8'h02, 1'b0);
      push_item(8'hAA, 1'b0);
      push_item(8'h55, 1'b0);
      // track ends inside a pitch bend
      push_item(8'h00, 1'b0);
      push_item(8'hE3, 1'b0);
      push_item(8'h10, 1'b1);
      track_count = 1;
      directed_count = pending_bytes.size();

      while (pending_bytes.size() < directed_count + RANDOM_ITEMS) gen_track();
      total_items = pending_bytes.size();

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      wait (acc_count == total_items);
      wait (expected_events.size() == 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (expected_events.size() != 0)
         report_mismatch("results never seen", 32'(expected_events.size()), 32'd0);

      $display("run covered %0d track bytes in %0d tracks, %0d results checked",
               total_items, track_count, event_count);
      $display("%0d tracks cut short, %0d sysex or meta payload bytes, %0d mismatches",
               trunc_count, payload_count, mismatch_count);
      if (mismatch_count == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
